### sv/pcle_pkg.sv
package pcle_pkg;

	localparam int DEPTH_DEF  = 64;
	localparam int QDEPTH_DEF = 2;

	localparam int KIND_W  = 3;
	localparam int POS_W   = 7;
	localparam int VAL_W   = 8;
	localparam int COUNT_W = 7;

	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (VAL_W + 1 + 1 + COUNT_W + 1);

	localparam logic [VAL_W-1:0] SEP_BYTE = 8'h3A;

	// Raw operation codes as they arrive in tuser
	localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_READ    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REPLACE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MIRROR  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_PREFIX  = 3'd5;
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd6;

	typedef enum logic [2:0] {
		OP_INSERT,
		OP_DELETE,
		OP_READ,
		OP_REPLACE,
		OP_MIRROR,
		OP_PREFIX,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
	} item_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SHUP = 6'b000010,
		ST_WALK = 6'b000100,
		ST_FIND = 6'b001000,
		ST_CMP  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

endpackage

### sv/pcle_front.sv
module pcle_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pcle_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic [pcle_pkg::IN_TUSER_W-1:0]   s_tuser,
	output logic                              push_valid,
	input  logic                              push_ready,
	output pcle_pkg::item_t                   push_item
);

	logic            valid_s1;
	pcle_pkg::item_t item_s1;
	pcle_pkg::item_t item_dec;

	// Classify the raw code into an operation
	always_comb begin
		item_dec.position = s_tdata[pcle_pkg::POS_W-1:0];
		item_dec.value    = s_tdata[pcle_pkg::POS_W +: pcle_pkg::VAL_W];
		case (s_tuser)
			pcle_pkg::KIND_INSERT:  item_dec.op = pcle_pkg::OP_INSERT;
			pcle_pkg::KIND_DELETE:  item_dec.op = pcle_pkg::OP_DELETE;
			pcle_pkg::KIND_READ:    item_dec.op = pcle_pkg::OP_READ;
			pcle_pkg::KIND_REPLACE: item_dec.op = pcle_pkg::OP_REPLACE;
			pcle_pkg::KIND_MIRROR:  item_dec.op = pcle_pkg::OP_MIRROR;
			pcle_pkg::KIND_PREFIX:  item_dec.op = pcle_pkg::OP_PREFIX;
			pcle_pkg::KIND_CLEAR:   item_dec.op = pcle_pkg::OP_CLEAR;
			default:                item_dec.op = pcle_pkg::OP_NOP;
		endcase
	end

	assign s_tready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_dec;
		end
	end

endmodule

### sv/pcle_queue.sv
module pcle_queue #(
	parameter int QDEPTH = pcle_pkg::QDEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  pcle_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop,
	output pcle_pkg::item_t pop_item
);

	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	pcle_pkg::item_t  slot_q [QDEPTH];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QCW-1:0]   fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != QCW'(QDEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_item   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : QAW'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : QAW'(rd_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				fill_q <= QCW'(fill_q + 1'b1);
			end else if (do_pop && !do_push) begin
				fill_q <= QCW'(fill_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

### sv/pcle_back.sv
module pcle_back #(
	parameter int DEPTH = pcle_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_pop,
	input  pcle_pkg::item_t                  q_item,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pcle_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > pcle_pkg::POS_W) ? CW : pcle_pkg::POS_W;

	// Entry store: one write port, two registered read ports
	logic [pcle_pkg::VAL_W-1:0] mem [DEPTH];
	logic [pcle_pkg::VAL_W-1:0] rda_q, rdb_q;
	logic                       ra_en, rb_en, we;
	logic [AW-1:0]              ra_addr, rb_addr, wa;
	logic [pcle_pkg::VAL_W-1:0] wd;

	pcle_pkg::state_t           st_q, st_d;
	logic [CW-1:0]              cnt_q, cnt_d;
	logic                       ovalid_q, ovalid_d;
	logic                       pend_q, pend_d;
	logic                       fin_q, fin_d;
	logic                       found_q, found_d;

	pcle_pkg::op_t              op_q, op_d;
	logic [AW-1:0]              pos_q, pos_d;
	logic [pcle_pkg::VAL_W-1:0] val_q, val_d;
	logic [AW-1:0]              idx_q, idx_d;
	logic [AW-1:0]              ib_q, ib_d;
	logic [AW-1:0]              end_q, end_d;
	logic [AW-1:0]              left_q, left_d;
	logic [AW-1:0]              pidx_q, pidx_d;
	logic [AW-1:0]              sep_q, sep_d;
	logic [pcle_pkg::VAL_W-1:0] rd_q, rd_d;
	logic                       err_q, err_d;
	logic                       pass_q, pass_d;
	logic [pcle_pkg::OUT_TDATA_W-1:0] odata_q, odata_d;

	logic [CMPW-1:0]            pos_w, cnt_w;
	logic [AW-1:0]              last_w, right_w;

	assign pos_w   = CMPW'(q_item.position);
	assign cnt_w   = CMPW'(cnt_q);
	assign last_w  = AW'(cnt_q - CW'(1));
	assign right_w = AW'(cnt_q - CW'(1) - CW'(sep_q));
	assign q_pop   = (st_q == pcle_pkg::ST_IDLE) && q_valid;

	always_comb begin
		st_d     = st_q;
		cnt_d    = cnt_q;
		ovalid_d = ovalid_q;
		pend_d   = 1'b0;
		fin_d    = fin_q;
		found_d  = found_q;
		op_d     = op_q;
		pos_d    = pos_q;
		val_d    = val_q;
		idx_d    = idx_q;
		ib_d     = ib_q;
		end_d    = end_q;
		left_d   = left_q;
		pidx_d   = pidx_q;
		sep_d    = sep_q;
		rd_d     = rd_q;
		err_d    = err_q;
		pass_d   = pass_q;
		odata_d  = odata_q;
		ra_en    = 1'b0;
		rb_en    = 1'b0;
		ra_addr  = idx_q;
		rb_addr  = ib_q;
		we       = 1'b0;
		wa       = idx_q;
		wd       = rda_q;

		if (m_tready) begin
			ovalid_d = 1'b0;
		end

		case (st_q)
			pcle_pkg::ST_IDLE: begin
				if (q_valid) begin
					op_d    = q_item.op;
					pos_d   = AW'(q_item.position);
					val_d   = q_item.value;
					rd_d    = '0;
					err_d   = 1'b0;
					pass_d  = 1'b0;
					found_d = 1'b0;
					fin_d   = 1'b0;
					st_d    = pcle_pkg::ST_DONE;
					case (q_item.op)
						pcle_pkg::OP_INSERT: begin
							if (pos_w > cnt_w || cnt_q == CW'(DEPTH)) begin
								err_d = 1'b1;
							end else if (pos_w == cnt_w) begin
								we    = 1'b1;
								wa    = AW'(q_item.position);
								wd    = q_item.value;
								cnt_d = CW'(cnt_q + 1'b1);
							end else begin
								idx_d = last_w;
								st_d  = pcle_pkg::ST_SHUP;
							end
						end
						pcle_pkg::OP_DELETE, pcle_pkg::OP_READ: begin
							if (pos_w >= cnt_w) begin
								err_d = 1'b1;
							end else begin
								idx_d = AW'(q_item.position);
								end_d = (q_item.op == pcle_pkg::OP_DELETE) ?
									last_w : AW'(q_item.position);
								st_d  = pcle_pkg::ST_WALK;
							end
						end
						pcle_pkg::OP_REPLACE: begin
							if (pos_w >= cnt_w) begin
								err_d = 1'b1;
							end else begin
								we = 1'b1;
								wa = AW'(q_item.position);
								wd = q_item.value;
							end
						end
						pcle_pkg::OP_MIRROR, pcle_pkg::OP_PREFIX: begin
							if (cnt_q != '0) begin
								idx_d = '0;
								end_d = last_w;
								st_d  = pcle_pkg::ST_FIND;
							end
						end
						pcle_pkg::OP_CLEAR: begin
							cnt_d = '0;
						end
						default: begin
						end
					endcase
				end
			end

			// Move entries up one place, top first, then drop the new byte in
			pcle_pkg::ST_SHUP: begin
				if (!fin_q) begin
					ra_en   = 1'b1;
					ra_addr = idx_q;
					pend_d  = 1'b1;
					pidx_d  = idx_q;
					if (idx_q == pos_q) begin
						fin_d = 1'b1;
					end else begin
						idx_d = AW'(idx_q - 1'b1);
					end
				end
				if (pend_q) begin
					we = 1'b1;
					wa = AW'(pidx_q + 1'b1);
					wd = rda_q;
				end else if (fin_q) begin
					we    = 1'b1;
					wa    = pos_q;
					wd    = val_q;
					cnt_d = CW'(cnt_q + 1'b1);
					st_d  = pcle_pkg::ST_DONE;
				end
			end

			// Read the target entry; for a delete also move later entries down
			pcle_pkg::ST_WALK: begin
				if (!fin_q) begin
					ra_en   = 1'b1;
					ra_addr = idx_q;
					pend_d  = 1'b1;
					pidx_d  = idx_q;
					if (idx_q == end_q) begin
						fin_d = 1'b1;
					end else begin
						idx_d = AW'(idx_q + 1'b1);
					end
				end
				if (pend_q) begin
					if (pidx_q == pos_q) begin
						rd_d = rda_q;
					end else if (op_q == pcle_pkg::OP_DELETE) begin
						we = 1'b1;
						wa = AW'(pidx_q - 1'b1);
						wd = rda_q;
					end
				end else if (fin_q) begin
					if (op_q == pcle_pkg::OP_DELETE) begin
						cnt_d = CW'(cnt_q - 1'b1);
					end
					st_d = pcle_pkg::ST_DONE;
				end
			end

			// Locate the first separator
			pcle_pkg::ST_FIND: begin
				if (!fin_q) begin
					ra_en   = 1'b1;
					ra_addr = idx_q;
					pend_d  = 1'b1;
					pidx_d  = idx_q;
					if (idx_q == end_q) begin
						fin_d = 1'b1;
					end else begin
						idx_d = AW'(idx_q + 1'b1);
					end
				end
				if (pend_q) begin
					if (!found_q && rda_q == pcle_pkg::SEP_BYTE) begin
						found_d = 1'b1;
						sep_d   = pidx_q;
					end
				end else if (fin_q) begin
					st_d = pcle_pkg::ST_DONE;
					if (!found_q) begin
						pass_d = 1'b0;
					end else if (op_q == pcle_pkg::OP_MIRROR && right_w > sep_q) begin
						pass_d = 1'b0;
					end else if (right_w == '0) begin
						pass_d = 1'b1;
					end else begin
						pass_d = 1'b1;
						left_d = right_w;
						idx_d  = AW'(sep_q + 1'b1);
						ib_d   = (op_q == pcle_pkg::OP_MIRROR) ? AW'(sep_q - 1'b1) : '0;
						fin_d  = 1'b0;
						st_d   = pcle_pkg::ST_CMP;
					end
				end
			end

			// Compare the right part against the left part, one pair a cycle
			pcle_pkg::ST_CMP: begin
				if (!fin_q) begin
					ra_en   = 1'b1;
					rb_en   = 1'b1;
					ra_addr = idx_q;
					rb_addr = ib_q;
					pend_d  = 1'b1;
					idx_d   = AW'(idx_q + 1'b1);
					ib_d    = (op_q == pcle_pkg::OP_MIRROR) ?
						AW'(ib_q - 1'b1) : AW'(ib_q + 1'b1);
					left_d  = AW'(left_q - 1'b1);
					if (left_q == AW'(1)) begin
						fin_d = 1'b1;
					end
				end
				if (pend_q) begin
					if (rda_q != rdb_q) begin
						pass_d = 1'b0;
					end
				end else if (fin_q) begin
					st_d = pcle_pkg::ST_DONE;
				end
			end

			pcle_pkg::ST_DONE: begin
				if (!ovalid_q || m_tready) begin
					odata_d  = {
						{pcle_pkg::OUT_PAD_W{1'b0}},
						(cnt_q == '0),
						pcle_pkg::COUNT_W'(cnt_q),
						pass_q,
						err_q,
						rd_q
					};
					ovalid_d = 1'b1;
					st_d     = pcle_pkg::ST_IDLE;
				end
			end

			default: begin
				st_d = pcle_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= pcle_pkg::ST_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
			pend_q   <= 1'b0;
			fin_q    <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			st_q     <= st_d;
			cnt_q    <= cnt_d;
			ovalid_q <= ovalid_d;
			pend_q   <= pend_d;
			fin_q    <= fin_d;
			found_q  <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		pos_q   <= pos_d;
		val_q   <= val_d;
		idx_q   <= idx_d;
		ib_q    <= ib_d;
		end_q   <= end_d;
		left_q  <= left_d;
		pidx_q  <= pidx_d;
		sep_q   <= sep_d;
		rd_q    <= rd_d;
		err_q   <= err_d;
		pass_q  <= pass_d;
		odata_q <= odata_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (ra_en) begin
			rda_q <= mem[ra_addr];
		end
		if (rb_en) begin
			rdb_q <= mem[rb_addr];
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count beyond capacity");

	a_write_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (CW'(wa) <= cnt_q))
		else $error("store write outside the list");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == pcle_pkg::ST_DONE && (!ovalid_q || m_tready))
			|=> (m_tvalid && st_q == pcle_pkg::ST_IDLE))
		else $error("finished item not delivered");

endmodule

### sv/positional_char_list_engine.sv
// Positional byte list engine.
// Input channel s_*: one item per operation. tuser carries the operation code
// (insert, delete, read, replace, mirror check, prefix check, clear); tdata
// carries the list position and the byte value.
// Output channel m_*: exactly one result item per input item, in order.
// The front stage registers and classifies items and hands them through a
// short queue to the execution unit, so input keeps flowing while the unit
// works or while a result waits on the output register.
// In the execution unit, replace, clear, an unused kind, an append, any error
// and a check of an empty list need no walk over the store. Read, delete and
// an insert below the count walk the entries; a check first searches for the
// separator and then, when needed, compares the part after the separator with
// the part before it.
// The walk over the single-write entry store moves or compares one entry per
// cycle.
// Reset empties the list at once; entries are never read above the count.
// When the receiver stalls, the result is held in the output register, the
// unit finishes the next item and waits, and the queue then fills up before
// s_tready falls.
module positional_char_list_engine #(
	parameter int DEPTH  = pcle_pkg::DEPTH_DEF,
	parameter int QDEPTH = pcle_pkg::QDEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [6:0] position, [14:7] value, [15] zero
	input  logic [pcle_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [2:0] kind
	input  logic [pcle_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] read_value, [8] op_error, [9] check_pass, [16:10] entry_count,
	// [17] is_empty, [23:18] zero
	output logic [pcle_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// Front stage to queue
	logic            push_valid;
	logic            push_ready;
	pcle_pkg::item_t push_item;

	// Queue to execution unit
	logic            q_valid;
	logic            q_pop;
	pcle_pkg::item_t q_item;

	pcle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	pcle_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_item)
	);

	// Execution unit: owns the entry store, the count and the output register
	pcle_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
